[hdl/osm_pkg.sv]
// shared types and constants for the order statistic multiset
`default_nettype none
package osm_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned RANK_W       = 11;
  localparam int unsigned IN_DATA_W    = 48;
  localparam int unsigned OUT_DATA_W   = 32;

  localparam logic [VAL_W-1:0] SENTINEL_MAX = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_RANK = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;
    logic             load;
    logic             shft;
    logic [VAL_W-1:0] value;
  } osm_cmd_t;

endpackage
`default_nettype wire

[hdl/osm_cell.sv]
// one cell of the sorted chain: stored value plus a readout shadow register
`default_nettype none
module osm_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 11
) (
  input  wire                             clk,
  input  wire osm_pkg::osm_cmd_t          cmd,
  input  wire [CNT_W-1:0]                 count,
  input  wire                             shift_in,
  input  wire [osm_pkg::VAL_W-1:0]        left_val,
  input  wire [osm_pkg::VAL_W-1:0]        right_sh,
  output logic                            shift_out,
  output logic [osm_pkg::VAL_W-1:0]       val,
  output logic [osm_pkg::VAL_W-1:0]       sh
);
  import osm_pkg::*;

  logic [VAL_W-1:0] val_r, val_nxt;
  logic [VAL_W-1:0] sh_r, sh_nxt;
  logic             occupied;
  logic             at_end;
  logic             gt;

  assign occupied = CNT_W'(INDEX) < count;
  assign at_end   = CNT_W'(INDEX) == count;
  assign gt       = occupied && ($signed(cmd.value) < $signed(val_r));

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (shift_in) begin
        val_nxt = left_val;
      end else if (gt || at_end) begin
        val_nxt = cmd.value;
      end
    end
  end

  always_comb begin
    sh_nxt = sh_r;
    if (cmd.load) begin
      sh_nxt = val_r;
    end else if (cmd.shft) begin
      sh_nxt = right_sh;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    sh_r  <= sh_nxt;
  end

  assign shift_out = gt;
  assign val       = val_r;
  assign sh        = sh_r;

endmodule
`default_nettype wire

[hdl/order_statistic_multiset.sv]
// top level of the order statistic multiset: control, cell chain and result stage
//
// Keeps a sorted multiset of signed 32-bit values in a chain of CAPACITY cells.
// Input channel in_*: in_tuser is the op (0 insert, 1 query), in_tdata carries
// value in bits 31:0 and rank in bits 42:32. Result channel out_*: out_tuser is
// the status (0 ok, 1 store full, 2 bad rank), out_tdata the answer.
// A word is taken when tvalid and tready are both high.
// An insert updates every cell in the cycle it is accepted, so inserts, bad
// ranks and sentinel queries go at one word per cycle while in_tready stays
// high; their result is registered into the output register or the skid.
// A query of stored rank r copies the chain into its shadow registers and
// shifts it toward cell 0 until cell 0 holds the r-th smallest value; the
// input is held off meanwhile and the result then goes to the result stage.
// A two-entry result stage (output register plus skid) lets a word be taken
// while the previous result waits; a stalled receiver holds the result and,
// once the skid is full, in_tready drops.
// Reset clears the item count and the handshake state; cell contents need
// no clearing since only cells below the count are ever read.
`default_nettype none
module order_statistic_multiset #(
  parameter int unsigned CAPACITY = osm_pkg::CAPACITY_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire [osm_pkg::IN_DATA_W-1:0]      in_tdata,   // value[31:0], rank[42:32], zero pad
  input  wire                               in_tuser,   // op
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [osm_pkg::OUT_DATA_W-1:0]    out_tdata,  // answer[31:0]
  output logic [1:0]                        out_tuser   // status[1:0]
);
  import osm_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = ((CNT_W > RANK_W) ? CNT_W : RANK_W) + 1;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] scnt_r, scnt_nxt;

  logic             out_v_r, out_v_nxt;
  logic [VAL_W-1:0] out_d_r, out_d_nxt;
  status_t          out_s_r, out_s_nxt;
  logic             skid_v_r, skid_v_nxt;
  logic [VAL_W-1:0] skid_d_r, skid_d_nxt;
  status_t          skid_s_r, skid_s_nxt;

  logic             accept;
  op_t              op;
  logic [VAL_W-1:0] in_value;
  logic [RANK_W-1:0] in_rank;
  logic [CMP_W-1:0] rank_ext, cnt_p1;
  logic             full, bad_rank, sentinel;
  logic             push, pop;
  logic [VAL_W-1:0] push_d;
  status_t          push_s;
  osm_cmd_t         cmd;

  logic [VAL_W-1:0] val_w [CAPACITY];
  logic [VAL_W-1:0] sh_w  [CAPACITY];
  logic             shf_w [CAPACITY];

  assign op       = op_t'(in_tuser);
  assign in_value = in_tdata[VAL_W-1:0];
  assign in_rank  = in_tdata[VAL_W+RANK_W-1:VAL_W];
  assign in_tready = !busy_r && !skid_v_r;
  assign accept    = in_tvalid && in_tready;

  assign rank_ext = CMP_W'(in_rank);
  assign cnt_p1   = CMP_W'(count_r) + CMP_W'(1);
  assign full     = count_r == CNT_W'(CAPACITY);
  assign bad_rank = (in_rank == '0) || (rank_ext > cnt_p1);
  assign sentinel = rank_ext == cnt_p1;

  always_comb begin
    cmd.ins   = accept && (op == OP_INSERT) && !full;
    cmd.load  = accept && (op == OP_QUERY) && !bad_rank && !sentinel;
    cmd.shft  = busy_r && (scnt_r != '0);
    cmd.value = in_value;
  end

  // control and result generation
  always_comb begin
    count_nxt = count_r;
    busy_nxt  = busy_r;
    scnt_nxt  = scnt_r;
    push      = 1'b0;
    push_d    = '0;
    push_s    = ST_OK;
    if (busy_r) begin
      if (scnt_r == '0) begin
        busy_nxt = 1'b0;
        push     = 1'b1;
        push_d   = sh_w[0];
      end else begin
        scnt_nxt = scnt_r - CNT_W'(1);
      end
    end else if (accept) begin
      if (op == OP_INSERT) begin
        push = 1'b1;
        if (full) begin
          push_s = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end else if (bad_rank) begin
        push   = 1'b1;
        push_s = ST_BAD_RANK;
      end else if (sentinel) begin
        push   = 1'b1;
        push_d = SENTINEL_MAX;
      end else begin
        busy_nxt = 1'b1;
        scnt_nxt = CNT_W'(rank_ext - CMP_W'(1));
      end
    end
  end

  // output register with skid
  assign pop = out_v_r && out_tready;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    out_s_nxt  = out_s_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    skid_s_nxt = skid_s_r;
    if (pop || !out_v_r) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        out_s_nxt  = skid_s_r;
        skid_v_nxt = push;
        skid_d_nxt = push_d;
        skid_s_nxt = push_s;
      end else begin
        out_v_nxt = push;
        out_d_nxt = push_d;
        out_s_nxt = push_s;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_d;
      skid_s_nxt = push_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      busy_r   <= 1'b0;
      scnt_r   <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      busy_r   <= busy_nxt;
      scnt_r   <= scnt_nxt;
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    out_s_r  <= out_s_nxt;
    skid_d_r <= skid_d_nxt;
    skid_s_r <= skid_s_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_s_r;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             sin;
    logic [VAL_W-1:0] lval;
    logic [VAL_W-1:0] rsh;

    if (i == 0) begin : g_first
      assign sin  = 1'b0;
      assign lval = '0;
    end else begin : g_mid
      assign sin  = shf_w[i-1];
      assign lval = val_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rsh = '0;
    end else begin : g_inner
      assign rsh = sh_w[i+1];
    end

    osm_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count_r),
      .shift_in  (sin),
      .left_val  (lval),
      .right_sh  (rsh),
      .shift_out (shf_w[i]),
      .val       (val_w[i]),
      .sh        (sh_w[i])
    );
  end

endmodule
`default_nettype wire
